// ----- design/mphs_pkg.sv -----
// package for the max pairwise horizontal separation block
// holds widths, status codes, controller states and the command/status structs
// no dependencies
`default_nettype none

package mphs_pkg;

  // default capacity of the point store
  localparam int unsigned MAX_SUBSETS_DEF = 16;

  // fixed field widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned SEP_W   = 33;
  localparam int unsigned SQ_W    = 66;
  localparam int unsigned ROOT_W  = 34;
  localparam int unsigned STAT_W  = 2;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FEW      = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_COMPARE,
    S_DRAIN,
    S_STORE,
    S_FINISH,
    S_ROOT,
    S_OUT
  } ctrl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic cap_in;
    logic rd_en;
    logic wr_en;
    logic clr_max;
    logic sqrt_start;
    logic load_out;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic sqrt_busy;
  } dp_sts_t;

endpackage : mphs_pkg

`default_nettype wire

// ----- design/mphs_isqrt.sv -----
// digit-by-digit floor square root, two radicand bits per cycle
// depends on mphs_pkg
`default_nettype none

module mphs_isqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [mphs_pkg::SQ_W-1:0]  radicand_i,
  output logic                            busy_o,
  output logic [mphs_pkg::SEP_W-1:0]      root_o
);
  import mphs_pkg::*;

  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned CNT_W  = $clog2(ROOT_W + 1);

  logic                busy_q, busy_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [RAD_W-1:0]    rad_q, rad_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [REM_W:0]      trial_rem;
  logic [REM_W:0]      trial_sub;

  // one root digit per step: bring down two bits, try subtracting 4r+1
  always_comb begin
    trial_rem = {rem_q[REM_W-2:0], rad_q[RAD_W-1 -: 2]};
    trial_sub = {1'b0, root_q, 2'b01};
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    rad_d     = rad_q;
    rem_d     = rem_q;
    root_d    = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(ROOT_W);
      rad_d  = RAD_W'(radicand_i);
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[RAD_W-3:0], 2'b00};
      if (trial_rem >= trial_sub) begin
        rem_d  = REM_W'(trial_rem - trial_sub);
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = REM_W'(trial_rem);
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q[SEP_W-1:0];

endmodule : mphs_isqrt

`default_nettype wire

// ----- design/mphs_dp.sv -----
// datapath: point memory, distance pipeline, running maximum, root unit, result register
// depends on mphs_pkg and mphs_isqrt
`default_nettype none

module mphs_dp #(
  parameter int unsigned MAX_SUBSETS = mphs_pkg::MAX_SUBSETS_DEF,
  parameter int unsigned AW          = $clog2(MAX_SUBSETS)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire mphs_pkg::dp_cmd_t            cmd_i,
  output mphs_pkg::dp_sts_t                 sts_o,
  input  wire logic [AW-1:0]                rd_addr_i,
  input  wire logic [AW-1:0]                wr_addr_i,
  input  wire logic [mphs_pkg::STAT_W-1:0]  out_status_i,
  input  wire logic [mphs_pkg::COORD_W-1:0] x_cm_i,
  input  wire logic [mphs_pkg::COORD_W-1:0] y_cm_i,
  output logic [mphs_pkg::SEP_W-1:0]        max_separation_cm_o,
  output logic [mphs_pkg::STAT_W-1:0]       status_o
);
  import mphs_pkg::*;

  localparam int unsigned PT_W = 2 * COORD_W;
  localparam int unsigned PR_W = 2 * COORD_W;

  logic [PT_W-1:0]    mem [MAX_SUBSETS];
  logic [COORD_W-1:0] x_q, y_q;
  logic [PT_W-1:0]    rd_q;
  logic               v1_q, v2_q, v3_q;
  logic [COORD_W-1:0] dx_q, dy_q, dx_d, dy_d;
  logic [PR_W-1:0]    sx_q, sy_q;
  logic [SQ_W-1:0]    max_q, sum;
  logic [COORD_W:0]   xab, xba, yab, yba;
  logic [SEP_W-1:0]   root;
  logic               sqrt_busy;
  logic [SEP_W-1:0]   sep_q;
  logic [STAT_W-1:0]  stat_q;

  // captured input point
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      x_q <= x_cm_i;
      y_q <= y_cm_i;
    end
  end

  // point memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr_i] <= {y_q, x_q};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // absolute differences: both signed subtractions, pick the non-negative one
  always_comb begin
    xab  = {rd_q[COORD_W-1], rd_q[COORD_W-1:0]} - {x_q[COORD_W-1], x_q};
    xba  = {x_q[COORD_W-1], x_q} - {rd_q[COORD_W-1], rd_q[COORD_W-1:0]};
    yab  = {rd_q[PT_W-1], rd_q[PT_W-1:COORD_W]} - {y_q[COORD_W-1], y_q};
    yba  = {y_q[COORD_W-1], y_q} - {rd_q[PT_W-1], rd_q[PT_W-1:COORD_W]};
    dx_d = xab[COORD_W] ? xba[COORD_W-1:0] : xab[COORD_W-1:0];
    dy_d = yab[COORD_W] ? yba[COORD_W-1:0] : yab[COORD_W-1:0];
    sum  = SQ_W'(sx_q) + SQ_W'(sy_q);
  end

  // pipeline payload: differences, then squares
  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
    sx_q <= dx_q * dx_q;
    sy_q <= dy_q * dy_q;
  end

  // pipeline valid bits and running maximum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      max_q <= '0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (cmd_i.clr_max) begin
        max_q <= '0;
      end else if (v3_q && (sum > max_q)) begin
        max_q <= sum;
      end
    end
  end

  // floor square root of the maximum
  mphs_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (max_q),
    .busy_o     (sqrt_busy),
    .root_o     (root)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sep_q  <= root;
      stat_q <= out_status_i;
    end
  end

  // status towards the controller
  always_comb begin
    sts_o.pipe_busy = v1_q | v2_q | v3_q;
    sts_o.sqrt_busy = sqrt_busy;
  end

  assign max_separation_cm_o = sep_q;
  assign status_o          = stat_q;

endmodule : mphs_dp

`default_nettype wire

// ----- design/mphs_ctrl.sv -----
// controller: epoch bookkeeping, compare sequencing and output handshake
// depends on mphs_pkg
`default_nettype none

module mphs_ctrl #(
  parameter int unsigned MAX_SUBSETS = mphs_pkg::MAX_SUBSETS_DEF,
  parameter int unsigned AW          = $clog2(MAX_SUBSETS),
  parameter int unsigned CW          = $clog2(MAX_SUBSETS + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         last_subset_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output mphs_pkg::dp_cmd_t                 cmd_o,
  input  wire mphs_pkg::dp_sts_t            sts_i,
  output logic [AW-1:0]                     rd_addr_o,
  output logic [AW-1:0]                     wr_addr_o,
  output logic [mphs_pkg::STAT_W-1:0]       out_status_o
);
  import mphs_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          last_q, last_d;
  logic          ovf_q, ovf_d;
  status_e       stat_q, stat_d;
  logic          out_valid_q, out_valid_d;
  logic          full;

  assign full = (cnt_q == CW'(MAX_SUBSETS));

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    last_d  = last_q;
    ovf_d   = ovf_q;
    stat_d  = stat_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          last_d       = last_subset_i;
          if (full) begin
            ovf_d   = 1'b1;
            state_d = last_subset_i ? S_FINISH : S_IDLE;
          end else begin
            idx_d   = '0;
            state_d = S_COMPARE;
          end
        end
      end
      S_COMPARE: begin
        if (idx_q == cnt_q) begin
          state_d = S_DRAIN;
        end else begin
          cmd_o.rd_en = 1'b1;
          idx_d       = idx_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.wr_en = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        state_d     = last_q ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        cmd_o.sqrt_start = 1'b1;
        cmd_o.clr_max    = 1'b1;
        if (cnt_q < CW'(2)) begin
          stat_d = STATUS_FEW;
        end else if (ovf_q) begin
          stat_d = STATUS_OVERFLOW;
        end else begin
          stat_d = STATUS_OK;
        end
        cnt_d   = '0;
        ovf_d   = 1'b0;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        if (!sts_i.sqrt_busy) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = cmd_o.load_out | (out_valid_q & out_stall_i);
  end

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      last_q      <= 1'b0;
      ovf_q       <= 1'b0;
      stat_q      <= STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      last_q      <= last_d;
      ovf_q       <= ovf_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign rd_addr_o    = idx_q[AW-1:0];
  assign wr_addr_o    = cnt_q[AW-1:0];
  assign out_status_o = stat_q;

`ifndef NO_ASSERTIONS
  // point count never passes the store capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_SUBSETS))
    else $error("point count beyond capacity");

  // a read only addresses a stored point
  a_rd_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> (idx_q < cnt_q))
    else $error("read of an unstored point");

  // the store is written only after all compares have retired
  a_wr_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> (!sts_i.pipe_busy && !full))
    else $error("point written while compares in flight or store full");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

  // the root unit is busy right after a start
  a_root_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sqrt_start |=> sts_i.sqrt_busy)
    else $error("root unit did not start");
`endif

endmodule : mphs_ctrl

`default_nettype wire

// ----- design/max_pairwise_horizontal_separation.sv -----
// top level: max pairwise horizontal separation of subset solutions
// depends on mphs_pkg, mphs_ctrl and mphs_dp
//
//   channel   direction   handshake                 payload
//   in        input       in_valid_i / in_stall_o   x_cm_i, y_cm_i, last_subset_i
//   out       output      out_valid_o / out_stall_i max_separation_cm_o, status_o
//
// a point that finds points stored makes one memory read per stored point through a four-stage
// distance pipeline, waits for the pipeline to drain, then writes the store
// the last point of an epoch then runs the two-bits-per-cycle square root
// a point beyond capacity is not stored; if it ends the epoch it starts the square root
// reset clears the epoch; the point memory is not cleared, only stored points are read
// a stalled result is held in the output register while the next epoch proceeds
`default_nettype none

module max_pairwise_horizontal_separation #(
  parameter int unsigned MAX_SUBSETS = mphs_pkg::MAX_SUBSETS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [mphs_pkg::COORD_W-1:0] x_cm_i,
  input  wire logic [mphs_pkg::COORD_W-1:0] y_cm_i,
  input  wire logic                         last_subset_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [mphs_pkg::SEP_W-1:0]        max_separation_cm_o,
  output logic [mphs_pkg::STAT_W-1:0]       status_o
);
  import mphs_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SUBSETS);
  localparam int unsigned CW = $clog2(MAX_SUBSETS + 1);

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [STAT_W-1:0] out_status;

  // sequencing
  mphs_ctrl #(
    .MAX_SUBSETS (MAX_SUBSETS),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .last_subset_i (last_subset_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cmd_o         (cmd),
    .sts_i         (sts),
    .rd_addr_o     (rd_addr),
    .wr_addr_o     (wr_addr),
    .out_status_o  (out_status)
  );

  // arithmetic and storage
  mphs_dp #(
    .MAX_SUBSETS (MAX_SUBSETS),
    .AW          (AW)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .rd_addr_i           (rd_addr),
    .wr_addr_i           (wr_addr),
    .out_status_i        (out_status),
    .x_cm_i              (x_cm_i),
    .y_cm_i              (y_cm_i),
    .max_separation_cm_o (max_separation_cm_o),
    .status_o            (status_o)
  );

endmodule : max_pairwise_horizontal_separation

`default_nettype wire

// ----- tb/mphs_separation_checker.sv -----
// checker for the max pairwise horizontal separation block
// predicts each epoch result from the accepted point transfers and compares it
// with the result transfers; depends on mphs_pkg
`timescale 1ns / 1ps

module mphs_separation_checker
  import mphs_pkg::*;
#(
  parameter int unsigned MAX_SUBSETS = MAX_SUBSETS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [COORD_W-1:0]  x_cm_i,
  input  logic [COORD_W-1:0]  y_cm_i,
  input  logic                last_subset_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [SEP_W-1:0]    max_separation_cm_i,
  input  logic [STAT_W-1:0]   status_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         pending_results_o
);

  typedef struct packed {
    logic [SEP_W-1:0] sep;
    status_e          status;
  } separation_result_t;

  // running copy of the epoch state
  logic [COORD_W-1:0] stored_x [MAX_SUBSETS];
  logic [COORD_W-1:0] stored_y [MAX_SUBSETS];
  int unsigned        stored_count = 0;
  logic [SQ_W-1:0]    widest_sq = '0;
  logic               extra_points = 1'b0;

  separation_result_t expected_separations [$];
  separation_result_t oldest;
  int unsigned        mismatches = 0;

  initial begin
    mismatch_count_o  = 0;
    pending_results_o = 0;
  end

  // exact squared horizontal distance between two points
  function automatic logic [SQ_W-1:0] distance_sq(input logic [COORD_W-1:0] ax, ay, bx, by);
    longint          ddx, ddy;
    logic [SQ_W-1:0] dx, dy;
    ddx = longint'($signed(ax)) - longint'($signed(bx));
    ddy = longint'($signed(ay)) - longint'($signed(by));
    if (ddx < 0) ddx = -ddx;
    if (ddy < 0) ddy = -ddy;
    dx = SQ_W'($unsigned(ddx));
    dy = SQ_W'($unsigned(ddy));
    return dx * dx + dy * dy;
  endfunction

  // floor square root, one result bit per pass, wide enough for the trial square
  function automatic logic [SEP_W-1:0] floor_root(input logic [SQ_W-1:0] v);
    logic [69:0] root;
    logic [69:0] trial;
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (70'd1 << b);
      if (trial * trial <= {4'b0, v}) root = trial;
    end
    return root[SEP_W-1:0];
  endfunction

  // fold one accepted point into the epoch, queue a result when it ends the epoch
  task automatic absorb_point(input logic [COORD_W-1:0] x, y, input logic last);
    logic [SQ_W-1:0]    d;
    separation_result_t res;
    if (stored_count < MAX_SUBSETS) begin
      for (int unsigned i = 0; i < stored_count; i++) begin
        d = distance_sq(stored_x[i], stored_y[i], x, y);
        if (d > widest_sq) widest_sq = d;
      end
      stored_x[stored_count] = x;
      stored_y[stored_count] = y;
      stored_count++;
    end else begin
      extra_points = 1'b1;
    end
    if (last) begin
      if (stored_count < 2) begin
        res.sep    = '0;
        res.status = STATUS_FEW;
      end else begin
        res.sep    = floor_root(widest_sq);
        res.status = extra_points ? STATUS_OVERFLOW : STATUS_OK;
      end
      expected_separations.push_back(res);
      stored_count = 0;
      widest_sq    = '0;
      extra_points = 1'b0;
    end
  endtask

  // watch both channels on every edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_count = 0;
      widest_sq    = '0;
      extra_points = 1'b0;
      expected_separations.delete();
      pending_results_o <= 0;
    end else begin
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0)
        absorb_point(x_cm_i, y_cm_i, last_subset_i);
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        if (expected_separations.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result transfer sep=%0d status=%0d",
                     $realtime, max_separation_cm_i, status_i);
          mismatches++;
        end else begin
          oldest = expected_separations.pop_front();
          if (oldest.sep !== max_separation_cm_i || oldest.status !== status_i) begin
            if (mismatches < 10)
              $display("%0t: result mismatch: expected sep=%0d status=%0d, got sep=%0d status=%0d",
                       $realtime, oldest.sep, oldest.status, max_separation_cm_i, status_i);
            mismatches++;
          end
        end
      end
      pending_results_o <= expected_separations.size();
      mismatch_count_o  <= mismatches;
    end
  end

endmodule

// ----- tb/max_pairwise_horizontal_separation_tb.sv -----
// testbench top for the max pairwise horizontal separation block
// drives point epochs under varying idle and stall patterns and gives the verdict;
// depends on mphs_pkg, the block and mphs_separation_checker
`timescale 1ns / 1ps

module max_pairwise_horizontal_separation_tb;
  import mphs_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned LONG_HOLD     = 1500;
  localparam int unsigned PHASE_POINTS  = 400;
  localparam int unsigned SETTLE_CYCLES = 100;

  localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;

  typedef enum int unsigned {
    STYLE_WIDE,
    STYLE_CLUSTER,
    STYLE_CORNER,
    STYLE_NEAR_ORIGIN
  } coord_style_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [COORD_W-1:0]  x_cm_i = '0;
  logic [COORD_W-1:0]  y_cm_i = '0;
  logic                last_subset_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [SEP_W-1:0]    max_separation_cm_o;
  logic [STAT_W-1:0]   status_o;

  int unsigned mismatch_count;
  int unsigned pending_results;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        long_hold_on = 1'b0;
  logic        hold_spent = 1'b0;
  int unsigned hold_count = 0;
  int unsigned stored_points = 0;

  max_pairwise_horizontal_separation uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .x_cm_i              (x_cm_i),
    .y_cm_i              (y_cm_i),
    .last_subset_i       (last_subset_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .max_separation_cm_o (max_separation_cm_o),
    .status_o            (status_o)
  );

  mphs_separation_checker separation_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .x_cm_i              (x_cm_i),
    .y_cm_i              (y_cm_i),
    .last_subset_i       (last_subset_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .max_separation_cm_i (max_separation_cm_o),
    .status_i            (status_o),
    .mismatch_count_o    (mismatch_count),
    .pending_results_o   (pending_results)
  );

  // 10 ns clock
  always #5 clk_i = ~clk_i;

  // result side: random stall, or one long hold-off while requested
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (long_hold_on && !hold_spent) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
    if (long_hold_on && !hold_spent) begin
      hold_count <= hold_count + 1;
      if (hold_count == LONG_HOLD - 1) hold_spent <= 1'b1;
    end else if (!long_hold_on) begin
      hold_count <= 0;
      hold_spent <= 1'b0;
    end
  end

  // watchdog
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // one point transfer, with random idle cycles in front
  task automatic send_point(input logic [COORD_W-1:0] x, y, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    x_cm_i        <= x;
    y_cm_i        <= y;
    last_subset_i <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // sender goes quiet until every queued result has come out
  // it steps the clock first so the count includes the point just accepted
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(input coord_style_e style,
                                                    input logic [COORD_W-1:0] centre);
    case (style)
      STYLE_WIDE:    return $urandom;
      STYLE_CLUSTER: return centre + COORD_W'($urandom_range(4000)) - 32'd2000;
      STYLE_CORNER: begin
        case ($urandom_range(4))
          0:       return COORD_MIN;
          1:       return COORD_MAX;
          2:       return 32'h0000_0000;
          3:       return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
      default:       return COORD_W'($urandom_range(200)) - 32'd100;
    endcase
  endfunction

  // one epoch of random points, points beyond capacity are ignored by the block
  task automatic send_epoch(input int unsigned points);
    coord_style_e       style;
    logic [COORD_W-1:0] cx, cy;
    style = coord_style_e'($urandom_range(3));
    cx = $urandom;
    cy = $urandom;
    for (int unsigned i = 0; i < points; i++)
      send_point(pick_coord(style, cx), pick_coord(style, cy), i == points - 1);
    stored_points += (points > MAX_SUBSETS_DEF) ? MAX_SUBSETS_DEF : points;
  endtask

  // epoch length: mostly normal, some single points and some over capacity
  function automatic int unsigned pick_epoch_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 1;
    if (r < 12) return $urandom_range(MAX_SUBSETS_DEF + 4, MAX_SUBSETS_DEF + 1);
    return $urandom_range(MAX_SUBSETS_DEF, 2);
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: a lone point
    send_point(32'd0, 32'd0, 1'b1);
    // opposite corners of the coordinate range
    send_point(COORD_MIN, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b1);
    send_point(COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MIN, COORD_MAX, 1'b1);
    // store full, then two ignored points that must not widen the result
    for (int unsigned i = 0; i < MAX_SUBSETS_DEF; i++)
      send_point(COORD_W'(i * 37), COORD_W'(-(i * 91)), 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b0);
    send_point(COORD_MIN, COORD_MIN, 1'b1);
    wait_drained();

    // long hold-off on the result side so the block backs up
    long_hold_on <= 1'b1;
    for (int unsigned e = 0; e < 8; e++) send_epoch(2);
    long_hold_on <= 1'b0;
    wait_drained();

    // random epochs over the idle and stall patterns
    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1:       begin send_idle_pct = 61; recv_stall_pct <= 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct <= 61; end
        default: begin send_idle_pct = 11; recv_stall_pct <= 11; end
      endcase
      stored_points = 0;
      while (stored_points < PHASE_POINTS) send_epoch(pick_epoch_length());
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
